>>> sv/tlsrg_pkg.sv
// Shared constants, register codes and helpers for the thin-lens ray generator.
package tlsrg_pkg;

  // Default number of fraction bits on the film and lens coordinates.
  localparam int COORD_FRAC_BITS_DEF = 14;

  // Configuration port index width and register codes.
  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_FILM_SIZE      = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_LENGTH   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_F_NUMBER       = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FOCUS_DISTANCE = 8'd3;

  // Register values after reset.
  localparam logic [15:0] FILM_SIZE_RST      = 16'd9216;
  localparam logic [15:0] FOCAL_LENGTH_RST   = 16'd12800;
  localparam logic [15:0] F_NUMBER_RST       = 16'd358;
  localparam logic [15:0] FOCUS_DISTANCE_RST = 16'd2560;

  // Quotient bits of the dividers and root bits of the square root.
  localparam int QW = 31;
  localparam int SW = 31;

  // Total register stages from input to output register.
  localparam int LATENCY = 2 + QW + 3 + SW + 2;

  // Saturate a 34-bit signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -34'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

>>> sv/thin_lens_sphere_ray_gen.sv
// Thin-lens camera ray generator: deep pipeline from film and lens samples to ray.
// Throughput: one request per cycle; the four long dividers and the square root are
// pipelined one quotient or root bit per stage, and the whole pipe holds while the
// output is stalled. Reset clears all valid bits and loads the register defaults;
// no clearing pass is needed, so requests are taken from the first cycle after reset.
module thin_lens_sphere_ray_gen import tlsrg_pkg::*; #(
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // Configuration write channel.
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [15:0]                 cfg_data,
  // Sample input channel.
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [15:0]          film_x,
  input  logic signed [15:0]          film_y,
  input  logic signed [15:0]          lens_u,
  input  logic signed [15:0]          lens_v,
  // Ray output channel.
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [31:0]          origin_y,
  output logic signed [31:0]          origin_z,
  output logic signed [31:0]          dir_x,
  output logic signed [31:0]          dir_y,
  output logic signed [31:0]          dir_z,
  output logic                        invalid
);

  localparam int C    = COORD_FRAC_BITS;
  localparam int DVW  = C + 27;
  localparam int RMW  = DVW + QW;
  localparam int REMW = SW + 4;

  typedef struct packed {
    logic [RMW-1:0] rem;
    logic [QW-1:0]  q;
  } lane_t;

  typedef struct packed {
    logic       bad;
    logic [3:0] neg;
  } dside_t;

  typedef struct packed {
    logic               bad;
    logic               neg_y;
    logic               neg_z;
    logic [QW-1:0]      qy;
    logic [QW-1:0]      qz;
    logic signed [31:0] oy;
    logic signed [31:0] oz;
  } carry_t;

  typedef struct packed {
    logic [REMW-1:0] rem;
    logic [SW-1:0]   root;
    logic [2*SW-1:0] rad;
  } sq_t;

  // Configuration registers.
  logic [15:0] film_size, focal_length, f_number, focus_distance;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      film_size      <= FILM_SIZE_RST;
      focal_length   <= FOCAL_LENGTH_RST;
      f_number       <= F_NUMBER_RST;
      focus_distance <= FOCUS_DISTANCE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FILM_SIZE:      film_size      <= cfg_data;
        REG_FOCAL_LENGTH:   focal_length   <= cfg_data;
        REG_F_NUMBER:       f_number       <= cfg_data;
        REG_FOCUS_DISTANCE: focus_distance <= cfg_data;
        default: ;
      endcase
    end
  end

  // Constants derived from the registers; they settle well before a request needs them.
  logic [15:0]     fl_c, fn_c;
  logic [DVW-1:0]  d_full;
  logic [DVW-1:0]  dty, doy;
  logic [24:0]     fn500;
  logic [63:0]     dsq;
  logic            d_small;

  assign fl_c = (focal_length == 16'd0) ? 16'd1 : focal_length;
  assign fn_c = (f_number == 16'd0) ? 16'd1 : f_number;

  always_ff @(posedge clk) begin
    d_full  <= DVW'(fl_c) << (C + 1);
    dty     <= DVW'(fl_c) << (C + 1);
    doy     <= DVW'(26'(fn_c) * 26'd1000) << C;
    fn500   <= 25'(fn_c) * 25'd500;
    dsq     <= 64'(d_full[31:0]) * 64'(d_full[31:0]);
    d_small <= (d_full >> 32) == '0;
  end

  // Pipeline advance and valid bits.
  logic               adv;
  logic [LATENCY-1:0] vld;

  assign adv       = !(out_valid && out_stall);
  assign in_stall  = !adv;
  assign out_valid = vld[LATENCY-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LATENCY-2:0], in_valid};
    end
  end

  // Stage 1: magnitudes and first products.
  logic [15:0] ax, ay, au, av;
  logic [31:0] am, bm, um, vm;
  logic [3:0]  sg1;

  assign ax = film_x[15] ? 16'(-film_x) : film_x;
  assign ay = film_y[15] ? 16'(-film_y) : film_y;
  assign au = lens_u[15] ? 16'(-lens_u) : lens_u;
  assign av = lens_v[15] ? 16'(-lens_v) : lens_v;

  always_ff @(posedge clk) begin
    if (adv) begin
      am  <= 32'(ax) * 32'(film_size);
      bm  <= 32'(ay) * 32'(film_size);
      um  <= 32'(au) * 32'(fl_c);
      vm  <= 32'(av) * 32'(fl_c);
      sg1 <= {film_y[15], film_x[15], lens_v[15], lens_u[15]};
    end
  end

  // Stage 2: squares for the sphere test and rounded division numerators.
  lane_t       dl  [0:QW][0:3];
  dside_t      dsb [0:QW];
  logic [63:0] am2, bm2;

  always_ff @(posedge clk) begin
    if (adv) begin
      am2          <= 64'(am) * 64'(am);
      bm2          <= 64'(bm) * 64'(bm);
      dl[0][0].rem <= (RMW'(um) << 16) + (RMW'(fn500) << C);
      dl[0][1].rem <= (RMW'(vm) << 16) + (RMW'(fn500) << C);
      dl[0][2].rem <= (RMW'(am) << 30) + (RMW'(fl_c) << C);
      dl[0][3].rem <= (RMW'(bm) << 30) + (RMW'(fl_c) << C);
      for (int l = 0; l < 4; l++) begin
        dl[0][l].q <= '0;
      end
      dsb[0].neg   <= sg1;
      dsb[0].bad   <= 1'b0;
    end
  end

  // Divider stages: one quotient bit per stage, restoring long division.
  for (genvar k = 1; k <= QW; k++) begin : g_div
    localparam int BI = QW - k;
    for (genvar l = 0; l < 4; l++) begin : g_lane
      lane_t          nxt;
      logic [RMW-1:0] sub;
      logic           ge;
      always_comb begin
        sub     = (l < 2) ? (RMW'(doy) << BI) : (RMW'(dty) << BI);
        ge      = dl[k-1][l].rem >= sub;
        nxt.rem = ge ? dl[k-1][l].rem - sub : dl[k-1][l].rem;
        nxt.q   = dl[k-1][l].q | (QW'(ge) << BI);
      end
      always_ff @(posedge clk) begin
        if (adv) begin
          dl[k][l] <= nxt;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dsb[k].neg <= dsb[k-1].neg;
        if (k == 1) begin
          dsb[k].bad <= d_small && (({1'b0, am2} + {1'b0, bm2}) > {1'b0, dsq});
        end else begin
          dsb[k].bad <= dsb[k-1].bad;
        end
      end
    end
  end

  // Stage 3: signed origin, target magnitudes.
  carry_t c3, c4;
  logic [63:0] sqy, sqz;

  always_ff @(posedge clk) begin
    if (adv) begin
      c3.bad   <= dsb[QW].bad;
      c3.neg_y <= dsb[QW].neg[2];
      c3.neg_z <= dsb[QW].neg[3];
      c3.qy    <= dl[QW][2].q;
      c3.qz    <= dl[QW][3].q;
      c3.oy    <= dsb[QW].neg[0] ? -$signed({1'b0, dl[QW][0].q}) : $signed({1'b0, dl[QW][0].q});
      c3.oz    <= dsb[QW].neg[1] ? -$signed({1'b0, dl[QW][1].q}) : $signed({1'b0, dl[QW][1].q});
    end
  end

  // Stage 4: squares of the target components.
  always_ff @(posedge clk) begin
    if (adv) begin
      c4  <= c3;
      sqy <= 64'(c3.qy) * 64'(c3.qy);
      sqz <= 64'(c3.qz) * 64'(c3.qz);
    end
  end

  // Stage 5: radicand, clamped at zero.
  sq_t    sqa [0:SW];
  carry_t crs [0:SW];
  logic [64:0] sq_sum;

  assign sq_sum = {1'b0, sqy} + {1'b0, sqz};

  always_ff @(posedge clk) begin
    if (adv) begin
      crs[0]      <= c4;
      sqa[0].rem  <= '0;
      sqa[0].root <= '0;
      sqa[0].rad  <= (sq_sum >= (65'd1 << 60)) ? '0 : (2*SW)'((65'd1 << 60) - sq_sum);
    end
  end

  // Square root stages: one root bit per stage, two radicand bits brought down each.
  for (genvar k = 1; k <= SW; k++) begin : g_sqrt
    sq_t             nxt;
    logic [REMW-1:0] rsh, trial;
    logic            ge;
    always_comb begin
      rsh      = {sqa[k-1].rem[REMW-3:0], sqa[k-1].rad[2*SW-1 -: 2]};
      trial    = REMW'({sqa[k-1].root, 2'b01});
      ge       = rsh >= trial;
      nxt.rem  = ge ? rsh - trial : rsh;
      nxt.root = {sqa[k-1].root[SW-2:0], ge};
      nxt.rad  = {sqa[k-1].rad[2*SW-3:0], 2'b00};
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        sqa[k] <= nxt;
        crs[k] <= crs[k-1];
      end
    end
  end

  // Stage 6: scale by the focus distance.
  carry_t      c6;
  logic [47:0] px, py, pz;

  always_ff @(posedge clk) begin
    if (adv) begin
      c6 <= crs[SW];
      px <= 48'(sqa[SW].root) * 48'(focus_distance);
      py <= 48'(crs[SW].qy) * 48'(focus_distance);
      pz <= 48'(crs[SW].qz) * 48'(focus_distance);
    end
  end

  // Stage 7: round to Q16, subtract the origin, saturate and zero invalid points.
  logic [25:0]        mx, my, mz;
  logic signed [33:0] tyr, tzr, dyw, dzw;

  always_comb begin
    mx  = 26'((px + 48'd2097152) >> 22);
    my  = 26'((py + 48'd2097152) >> 22);
    mz  = 26'((pz + 48'd2097152) >> 22);
    tyr = c6.neg_y ? -$signed(34'(my)) : $signed(34'(my));
    tzr = c6.neg_z ? -$signed(34'(mz)) : $signed(34'(mz));
    dyw = tyr - 34'(c6.oy);
    dzw = tzr - 34'(c6.oz);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      invalid <= c6.bad;
      if (c6.bad) begin
        origin_y <= '0;
        origin_z <= '0;
        dir_x    <= '0;
        dir_y    <= '0;
        dir_z    <= '0;
      end else begin
        origin_y <= c6.oy;
        origin_z <= c6.oz;
        dir_x    <= sat32($signed(34'(mx)));
        dir_y    <= sat32(dyw);
        dir_z    <= sat32(dzw);
      end
    end
  end

  // An invalid ray carries no geometry.
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && invalid |-> origin_y == 0 && origin_z == 0 && dir_x == 0 &&
                             dir_y == 0 && dir_z == 0)
    else $error("invalid ray with non-zero fields");

  // The input is held back only while a finished result waits.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a waiting result");

  // Nothing comes out in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result presented straight after reset");

endmodule
